// ===== rtl/frmr_pkg.sv =====
package frmr_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int PRODUCT_WIDTH = 2 * OPERAND_WIDTH;
   localparam int RESULT_WIDTH  = 32;
   localparam int SHIFT_WIDTH   = $clog2(PRODUCT_WIDTH);
   localparam int PC_WIDTH      = 4;
   localparam int OP_WIDTH      = 4;
   localparam int COND_WIDTH    = 4;

   typedef struct packed {
      logic signed [OPERAND_WIDTH-1:0] a_num;
      logic signed [OPERAND_WIDTH-1:0] a_den;
      logic signed [OPERAND_WIDTH-1:0] b_num;
      logic signed [OPERAND_WIDTH-1:0] b_den;
   } frmr_req_type;

   typedef struct packed {
      logic signed [RESULT_WIDTH-1:0] prod_num;
      logic signed [RESULT_WIDTH-1:0] prod_den;
   } frmr_rsp_type;

   localparam logic [OP_WIDTH-1:0] OP_NONE       = 4'd0;
   localparam logic [OP_WIDTH-1:0] OP_LOAD       = 4'd1;
   localparam logic [OP_WIDTH-1:0] OP_MUL        = 4'd2;
   localparam logic [OP_WIDTH-1:0] OP_MAG        = 4'd3;
   localparam logic [OP_WIDTH-1:0] OP_HALVE_BOTH = 4'd4;
   localparam logic [OP_WIDTH-1:0] OP_HALVE_U    = 4'd5;
   localparam logic [OP_WIDTH-1:0] OP_HALVE_V    = 4'd6;
   localparam logic [OP_WIDTH-1:0] OP_SUB        = 4'd7;
   localparam logic [OP_WIDTH-1:0] OP_DOUBLE_G   = 4'd8;
   localparam logic [OP_WIDTH-1:0] OP_DIV_INIT_N = 4'd9;
   localparam logic [OP_WIDTH-1:0] OP_DIV_STEP   = 4'd10;
   localparam logic [OP_WIDTH-1:0] OP_DIV_INIT_D = 4'd11;
   localparam logic [OP_WIDTH-1:0] OP_SAVE_D     = 4'd12;
   localparam logic [OP_WIDTH-1:0] OP_OUT        = 4'd13;

   localparam logic [COND_WIDTH-1:0] C_ALWAYS   = 4'd0;
   localparam logic [COND_WIDTH-1:0] C_START    = 4'd1;
   localparam logic [COND_WIDTH-1:0] C_ZERO     = 4'd2;
   localparam logic [COND_WIDTH-1:0] C_ODD_ANY  = 4'd3;
   localparam logic [COND_WIDTH-1:0] C_U_ODD    = 4'd4;
   localparam logic [COND_WIDTH-1:0] C_V_ODD    = 4'd5;
   localparam logic [COND_WIDTH-1:0] C_DIFF_NZ  = 4'd6;
   localparam logic [COND_WIDTH-1:0] C_K_ZERO   = 4'd7;
   localparam logic [COND_WIDTH-1:0] C_CNT_LAST = 4'd8;

   typedef struct packed {
      logic start;
      logic zero;
      logic odd_any;
      logic u_odd;
      logic v_odd;
      logic diff_nz;
      logic k_zero;
      logic cnt_last;
   } frmr_status_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0] op;
      logic                jump;
      logic                busy;
   } frmr_ctrl_type;

endpackage

// ===== rtl/fraction_multiply_reduce.sv =====
// Channel   Ports                      Transfer
// request   start, busy, req_data      start high while busy is low
// result    rsp_strobe, rsp_data       rsp_strobe high, one cycle, always taken
//
// A nonzero item keeps busy high while it runs the halving and subtract loops of the
// binary divisor search and two 32-step restoring divisions.
// An item with a zero product part skips both; the sequencer jumps from MAG to OUT.
// The result strobe comes in the first cycle with busy low; a new item may start then.
// Reset is synchronous and returns the sequencer to idle with no result pending.
module fraction_multiply_reduce (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  frmr_pkg::frmr_req_type req_data,
   output logic                   rsp_strobe,
   output frmr_pkg::frmr_rsp_type rsp_data
);

   localparam int PW = frmr_pkg::PRODUCT_WIDTH;
   localparam int SW = frmr_pkg::SHIFT_WIDTH;

   frmr_pkg::frmr_status_type status;
   frmr_pkg::frmr_ctrl_type   ctrl;

   frmr_pkg::frmr_req_type req_ff;
   logic signed [PW-1:0]   pn_ff;
   logic signed [PW-1:0]   pd_ff;
   logic [PW-1:0]          mag_n_ff;
   logic [PW-1:0]          mag_d_ff;
   logic [PW-1:0]          u_ff;
   logic [PW-1:0]          u_in;
   logic [PW-1:0]          v_ff;
   logic [PW-1:0]          v_in;
   logic [SW-1:0]          k_ff;
   logic [SW-1:0]          k_in;
   logic [PW-1:0]          rem_ff;
   logic [PW-1:0]          rem_in;
   logic [PW-1:0]          quo_ff;
   logic [PW-1:0]          quo_in;
   logic [SW-1:0]          cnt_ff;
   logic [SW-1:0]          cnt_in;
   logic [PW-1:0]          qn_ff;
   logic [PW-1:0]          qd_ff;
   frmr_pkg::frmr_rsp_type rsp_ff;
   logic                   strobe_ff;

   logic signed [PW-1:0] mul_n;
   logic signed [PW-1:0] mul_d;
   logic [PW-1:0]        abs_n;
   logic [PW-1:0]        abs_d;
   logic [PW:0]          trial;
   logic [PW:0]          trial_diff;
   logic [PW-1:0]        neg_n;
   logic [PW-1:0]        neg_d;

   assign mul_n = req_ff.a_num * req_ff.b_num;
   assign mul_d = req_ff.a_den * req_ff.b_den;
   assign abs_n = pn_ff[PW-1] ? (~pn_ff + 1'b1) : pn_ff;
   assign abs_d = pd_ff[PW-1] ? (~pd_ff + 1'b1) : pd_ff;
   assign trial      = {rem_ff, quo_ff[PW-1]};
   assign trial_diff = trial - {1'b0, u_ff};
   assign neg_n = pn_ff[PW-1] ? (~qn_ff + 1'b1) : qn_ff;
   assign neg_d = pd_ff[PW-1] ? (~qd_ff + 1'b1) : qd_ff;

   assign status.start    = start;
   assign status.zero     = (pn_ff == '0) || (pd_ff == '0);
   assign status.odd_any  = u_ff[0] | v_ff[0];
   assign status.u_odd    = u_ff[0];
   assign status.v_odd    = v_ff[0];
   assign status.diff_nz  = (u_ff != v_ff);
   assign status.k_zero   = (k_ff == '0);
   assign status.cnt_last = (cnt_ff == SW'(PW - 1));

   frmr_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   always_comb begin
      u_in   = u_ff;
      v_in   = v_ff;
      k_in   = k_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      case (ctrl.op)
         frmr_pkg::OP_MAG: begin
            u_in = abs_n;
            v_in = abs_d;
            k_in = '0;
         end
         frmr_pkg::OP_HALVE_BOTH: begin
            if (!ctrl.jump) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 1'b1;
            end
         end
         frmr_pkg::OP_HALVE_U: begin
            if (!ctrl.jump) begin
               u_in = u_ff >> 1;
            end
         end
         frmr_pkg::OP_HALVE_V: begin
            if (!ctrl.jump) begin
               v_in = v_ff >> 1;
            end
         end
         frmr_pkg::OP_SUB: begin
            if (v_ff >= u_ff) begin
               v_in = v_ff - u_ff;
            end else begin
               v_in = u_ff - v_ff;
               u_in = v_ff;
            end
         end
         frmr_pkg::OP_DOUBLE_G: begin
            if (!ctrl.jump) begin
               u_in = u_ff << 1;
               k_in = k_ff - 1'b1;
            end
         end
         frmr_pkg::OP_DIV_INIT_N: begin
            rem_in = '0;
            quo_in = mag_n_ff;
            cnt_in = '0;
         end
         frmr_pkg::OP_DIV_INIT_D: begin
            rem_in = '0;
            quo_in = mag_d_ff;
            cnt_in = '0;
         end
         frmr_pkg::OP_DIV_STEP: begin
            if (!trial_diff[PW]) begin
               rem_in = trial_diff[PW-1:0];
               quo_in = {quo_ff[PW-2:0], 1'b1};
            end else begin
               rem_in = trial[PW-1:0];
               quo_in = {quo_ff[PW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      u_ff   <= u_in;
      v_ff   <= v_in;
      k_ff   <= k_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (ctrl.op == frmr_pkg::OP_LOAD) begin
         req_ff <= req_data;
      end
      if (ctrl.op == frmr_pkg::OP_MUL) begin
         pn_ff <= mul_n;
         pd_ff <= mul_d;
      end
      if (ctrl.op == frmr_pkg::OP_MAG) begin
         mag_n_ff <= abs_n;
         mag_d_ff <= abs_d;
         qn_ff    <= abs_n;
         qd_ff    <= abs_d;
      end
      if (ctrl.op == frmr_pkg::OP_DIV_INIT_D) begin
         qn_ff <= quo_ff;
      end
      if (ctrl.op == frmr_pkg::OP_SAVE_D) begin
         qd_ff <= quo_ff;
      end
      if (ctrl.op == frmr_pkg::OP_OUT) begin
         rsp_ff.prod_num <= frmr_pkg::RESULT_WIDTH'(neg_n);
         rsp_ff.prod_den <= frmr_pkg::RESULT_WIDTH'(neg_d);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (ctrl.op == frmr_pkg::OP_OUT);
      end
   end

   assign busy       = ctrl.busy;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== rtl/frmr_seq.sv =====
module frmr_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  frmr_pkg::frmr_status_type status,
   output frmr_pkg::frmr_ctrl_type   ctrl
);

   typedef struct packed {
      logic [frmr_pkg::OP_WIDTH-1:0]   op;
      logic [frmr_pkg::COND_WIDTH-1:0] cond;
      logic [frmr_pkg::PC_WIDTH-1:0]   target;
      logic                            hold;
   } uword_type;

   localparam logic [frmr_pkg::PC_WIDTH-1:0] PC_IDLE      = 4'd0;
   localparam logic [frmr_pkg::PC_WIDTH-1:0] PC_MUL       = 4'd1;
   localparam logic [frmr_pkg::PC_WIDTH-1:0] PC_MAG       = 4'd2;
   localparam logic [frmr_pkg::PC_WIDTH-1:0] PC_TWOS      = 4'd3;
   localparam logic [frmr_pkg::PC_WIDTH-1:0] PC_U_EVEN    = 4'd4;
   localparam logic [frmr_pkg::PC_WIDTH-1:0] PC_V_EVEN    = 4'd5;
   localparam logic [frmr_pkg::PC_WIDTH-1:0] PC_SUB       = 4'd6;
   localparam logic [frmr_pkg::PC_WIDTH-1:0] PC_DOUBLE    = 4'd7;
   localparam logic [frmr_pkg::PC_WIDTH-1:0] PC_DIVN_INIT = 4'd8;
   localparam logic [frmr_pkg::PC_WIDTH-1:0] PC_DIVN      = 4'd9;
   localparam logic [frmr_pkg::PC_WIDTH-1:0] PC_DIVD_INIT = 4'd10;
   localparam logic [frmr_pkg::PC_WIDTH-1:0] PC_DIVD      = 4'd11;
   localparam logic [frmr_pkg::PC_WIDTH-1:0] PC_SAVE_D    = 4'd12;
   localparam logic [frmr_pkg::PC_WIDTH-1:0] PC_OUT       = 4'd13;

   function automatic uword_type rom_word(input logic [frmr_pkg::PC_WIDTH-1:0] addr);
      uword_type w;
      begin
         case (addr)
            PC_IDLE:      w = '{frmr_pkg::OP_LOAD, frmr_pkg::C_START, PC_MUL, 1'b1};
            PC_MUL:       w = '{frmr_pkg::OP_MUL, frmr_pkg::C_ALWAYS, PC_MAG, 1'b0};
            PC_MAG:       w = '{frmr_pkg::OP_MAG, frmr_pkg::C_ZERO, PC_OUT, 1'b0};
            PC_TWOS:      w = '{frmr_pkg::OP_HALVE_BOTH, frmr_pkg::C_ODD_ANY, PC_U_EVEN, 1'b1};
            PC_U_EVEN:    w = '{frmr_pkg::OP_HALVE_U, frmr_pkg::C_U_ODD, PC_V_EVEN, 1'b1};
            PC_V_EVEN:    w = '{frmr_pkg::OP_HALVE_V, frmr_pkg::C_V_ODD, PC_SUB, 1'b1};
            PC_SUB:       w = '{frmr_pkg::OP_SUB, frmr_pkg::C_DIFF_NZ, PC_V_EVEN, 1'b0};
            PC_DOUBLE:    w = '{frmr_pkg::OP_DOUBLE_G, frmr_pkg::C_K_ZERO, PC_DIVN_INIT, 1'b1};
            PC_DIVN_INIT: w = '{frmr_pkg::OP_DIV_INIT_N, frmr_pkg::C_ALWAYS, PC_DIVN, 1'b0};
            PC_DIVN:      w = '{frmr_pkg::OP_DIV_STEP, frmr_pkg::C_CNT_LAST, PC_DIVD_INIT, 1'b1};
            PC_DIVD_INIT: w = '{frmr_pkg::OP_DIV_INIT_D, frmr_pkg::C_ALWAYS, PC_DIVD, 1'b0};
            PC_DIVD:      w = '{frmr_pkg::OP_DIV_STEP, frmr_pkg::C_CNT_LAST, PC_SAVE_D, 1'b1};
            PC_SAVE_D:    w = '{frmr_pkg::OP_SAVE_D, frmr_pkg::C_ALWAYS, PC_OUT, 1'b0};
            PC_OUT:       w = '{frmr_pkg::OP_OUT, frmr_pkg::C_ALWAYS, PC_IDLE, 1'b0};
            default:      w = '{frmr_pkg::OP_NONE, frmr_pkg::C_ALWAYS, PC_IDLE, 1'b0};
         endcase
         return w;
      end
   endfunction

   logic [frmr_pkg::PC_WIDTH-1:0] pc_ff;
   logic [frmr_pkg::PC_WIDTH-1:0] pc_in;
   uword_type                     word;
   logic                          taken;

   assign word = rom_word(pc_ff);

   always_comb begin
      case (word.cond)
         frmr_pkg::C_ALWAYS:   taken = 1'b1;
         frmr_pkg::C_START:    taken = status.start;
         frmr_pkg::C_ZERO:     taken = status.zero;
         frmr_pkg::C_ODD_ANY:  taken = status.odd_any;
         frmr_pkg::C_U_ODD:    taken = status.u_odd;
         frmr_pkg::C_V_ODD:    taken = status.v_odd;
         frmr_pkg::C_DIFF_NZ:  taken = status.diff_nz;
         frmr_pkg::C_K_ZERO:   taken = status.k_zero;
         frmr_pkg::C_CNT_LAST: taken = status.cnt_last;
         default:              taken = 1'b1;
      endcase
   end

   always_comb begin
      if (taken) begin
         pc_in = word.target;
      end else if (word.hold) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.op   = word.op;
   assign ctrl.jump = taken;
   assign ctrl.busy = (pc_ff != PC_IDLE);

endmodule

// ===== rtl/frmr_chk.sv =====
module frmr_chk (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   a_start_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted request did not raise busy.");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy || $past(busy)) && $past(busy))
      else $error("Result strobe without a preceding busy period.");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Result strobe lasted more than one cycle.");

   a_fall_gives_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("Busy fell without a result transfer.");

endmodule

bind fraction_multiply_reduce frmr_chk u_frmr_chk (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

// ===== verif/fraction_multiply_reduce_tb.sv =====
`timescale 1ns / 100ps

module fraction_multiply_reduce_tb;

   localparam int RESET_CYCLES   = 9;
   localparam int RANDOM_ITEMS   = 1800;
   localparam int STEADY_ITEMS   = 250;
   localparam int STALL_LIMIT    = 4000;
   localparam int DRAIN_CYCLES   = 300;
   localparam int REPORT_LIMIT   = 10;

   typedef logic signed [frmr_pkg::OPERAND_WIDTH-1:0] operand_type;
   typedef logic signed [frmr_pkg::RESULT_WIDTH-1:0]  part_type;

   typedef struct {
      frmr_pkg::frmr_req_type stim;
      bit                     typed;
      frmr_pkg::frmr_rsp_type want;
   } case_row_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   frmr_pkg::frmr_req_type req_data;
   logic                   rsp_strobe;
   frmr_pkg::frmr_rsp_type rsp_data;

   frmr_pkg::frmr_rsp_type pending_products[$];
   case_row_type           directed_rows[$];
   int                     mismatch_count;
   int                     stall_cycles;

   fraction_multiply_reduce u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic frmr_pkg::frmr_rsp_type reduce_product(
         input frmr_pkg::frmr_req_type stim);
      frmr_pkg::frmr_rsp_type result;
      longint               num;
      longint               den;
      longint unsigned      num_mag;
      longint unsigned      den_mag;
      longint unsigned      p;
      longint unsigned      q;
      longint unsigned      r;
      longint unsigned      divisor;
      num = longint'(stim.a_num) * longint'(stim.b_num);
      den = longint'(stim.a_den) * longint'(stim.b_den);
      num_mag = (num < 0) ? longint'(-num) : longint'(num);
      den_mag = (den < 0) ? longint'(-den) : longint'(den);
      divisor = 1;
      if (num_mag != 0 && den_mag != 0) begin
         p = num_mag;
         q = den_mag;
         while (q != 0) begin
            r = p % q;
            p = q;
            q = r;
         end
         divisor = p;
      end
      num = (num < 0) ? -longint'(num_mag / divisor) : longint'(num_mag / divisor);
      den = (den < 0) ? -longint'(den_mag / divisor) : longint'(den_mag / divisor);
      result.prod_num = num[frmr_pkg::RESULT_WIDTH-1:0];
      result.prod_den = den[frmr_pkg::RESULT_WIDTH-1:0];
      return result;
   endfunction

   function automatic case_row_type make_row(input int an, input int ad, input int bn,
                                             input int bd, input bit typed,
                                             input longint wn, input longint wd);
      case_row_type row;
      row.stim.a_num    = operand_type'(an);
      row.stim.a_den    = operand_type'(ad);
      row.stim.b_num    = operand_type'(bn);
      row.stim.b_den    = operand_type'(bd);
      row.typed         = typed;
      row.want.prod_num = part_type'(wn);
      row.want.prod_den = part_type'(wd);
      return row;
   endfunction

   function automatic operand_type pick_operand();
      operand_type value;
      int          pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2: begin
            value = operand_type'($urandom);
         end
         3: begin
            case ($urandom_range(0, 4))
               0: value = operand_type'(-32768);
               1: value = operand_type'(32767);
               2: value = operand_type'(0);
               3: value = operand_type'(1);
               default: value = operand_type'(-1);
            endcase
         end
         4, 5: begin
            value = operand_type'(int'($urandom_range(0, 40)) - 20);
         end
         default: begin
            value = operand_type'(int'($urandom_range(1, 255)) << $urandom_range(0, 7));
            if ($urandom_range(0, 1) == 1) begin
               value = -value;
            end
         end
      endcase
      return value;
   endfunction

   function automatic frmr_pkg::frmr_req_type random_pair();
      frmr_pkg::frmr_req_type stim;
      int                     factor;
      stim.a_num = pick_operand();
      stim.a_den = pick_operand();
      stim.b_num = pick_operand();
      stim.b_den = pick_operand();
      if ($urandom_range(0, 2) == 0) begin
         factor = $urandom_range(2, 180);
         stim.a_num = operand_type'(factor * (int'($urandom_range(0, 360)) - 180));
         stim.b_den = operand_type'(factor * (int'($urandom_range(0, 360)) - 180));
      end
      return stim;
   endfunction

   task automatic issue_pair(input frmr_pkg::frmr_req_type stim, input bit typed,
                             input frmr_pkg::frmr_rsp_type want, input bit may_idle);
      int gap;
      gap = (may_idle && $urandom_range(0, 2) == 0) ? $urandom_range(1, 11) : 0;
      @(negedge clock);
      if (gap != 0) begin
         start    <= 1'b0;
         req_data <= frmr_pkg::frmr_req_type'({$urandom, $urandom});
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= stim;
      while (busy) @(negedge clock);
      @(posedge clock);
      pending_products.push_back(typed ? want : reduce_product(stim));
   endtask

   always @(posedge clock) begin
      frmr_pkg::frmr_rsp_type expected;
      if (!reset && rsp_strobe) begin
         if (pending_products.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("Unexpected result %0d/%0d", rsp_data.prod_num, rsp_data.prod_den);
            end
         end else begin
            expected = pending_products.pop_front();
            if (rsp_data.prod_num !== expected.prod_num
                || rsp_data.prod_den !== expected.prod_den) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("Mismatch: expected %0d/%0d, got %0d/%0d",
                           expected.prod_num, expected.prod_den,
                           rsp_data.prod_num, rsp_data.prod_den);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      frmr_pkg::frmr_rsp_type unused;
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      unused         = '0;

      // A zero part in either product passes through unreduced; signs stay where they fall.
      directed_rows.push_back(make_row(0, 0, 0, 0, 1, 0, 0));
      directed_rows.push_back(make_row(3, 0, 2, 5, 1, 6, 0));
      directed_rows.push_back(make_row(5, 0, -7, 0, 1, -35, 0));
      directed_rows.push_back(make_row(0, 5, 3, 7, 1, 0, 35));
      directed_rows.push_back(make_row(7, 3, 0, 0, 1, 0, 0));
      directed_rows.push_back(make_row(-32768, 1, -32768, 1, 1, 1073741824, 1));
      directed_rows.push_back(make_row(32767, 1, -32768, 1, 1, -1073709056, 1));
      directed_rows.push_back(make_row(1, -32768, 1, -32768, 1, 1, 1073741824));
      directed_rows.push_back(make_row(-32768, -32768, -32768, -32768, 1, 1, 1));
      directed_rows.push_back(make_row(32767, 32767, 32767, 32767, 1, 1, 1));
      directed_rows.push_back(make_row(1, -1, 1, 1, 1, 1, -1));
      directed_rows.push_back(make_row(-1, -1, 1, 1, 1, -1, -1));
      directed_rows.push_back(make_row(6, 4, 2, 3, 0, 0, 0));
      directed_rows.push_back(make_row(-12, 18, 9, -4, 0, 0, 0));
      directed_rows.push_back(make_row(32767, -32768, -32768, 32767, 0, 0, 0));
      directed_rows.push_back(make_row(12345, -6789, -4321, 9876, 0, 0, 0));
      directed_rows.push_back(make_row(-32768, 2, 16384, -32768, 0, 0, 0));
      directed_rows.push_back(make_row(1024, 768, 96, 4096, 0, 0, 0));
      directed_rows.push_back(make_row(-21846, 21845, -1, 3, 0, 0, 0));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         issue_pair(directed_rows[i].stim, directed_rows[i].typed,
                    directed_rows[i].want, 1'b0);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         issue_pair(random_pair(), 1'b0, unused,
                    (n < RANDOM_ITEMS - STEADY_ITEMS) && ((n / 60) % 3 != 2));
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_products.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/frmr_pkg.sv
rtl/frmr_seq.sv
rtl/fraction_multiply_reduce.sv
rtl/frmr_chk.sv
verif/fraction_multiply_reduce_tb.sv
